@@ sv/dtq_pkg.sv @@
// Shared constants for the deadline timer queue.
`timescale 1ns / 1ps
package dtq_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int ID_SPACE  = 16;
  localparam int ID_W      = 4;
  localparam int TIME_W    = 32;
  localparam int OP_W      = 2;
  localparam int ST_W      = 3;

  localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL   = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN      = 2'd2;

  localparam logic [ST_W-1:0] ST_QUEUED     = 3'd0;
  localparam logic [ST_W-1:0] ST_ALREADY    = 3'd1;
  localparam logic [ST_W-1:0] ST_CANCELLED  = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_QUEUED = 3'd3;
  localparam logic [ST_W-1:0] ST_FIRED      = 3'd4;
  localparam logic [ST_W-1:0] ST_NONE_DUE   = 3'd5;

endpackage

@@ sv/dtq_alu.sv @@
// Shared 32-bit add/subtract unit: due time on schedule, wrap-safe difference on scan.
`timescale 1ns / 1ps
module dtq_alu (
  input  logic                        sub,
  input  logic [dtq_pkg::TIME_W-1:0]  a,
  input  logic [dtq_pkg::TIME_W-1:0]  b,
  output logic [dtq_pkg::TIME_W-1:0]  sum
);

  logic [dtq_pkg::TIME_W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign sum  = a + b_op + {{(dtq_pkg::TIME_W-1){1'b0}}, sub};

endmodule

@@ sv/deadline_timer_queue.sv @@
// Deadline timer queue: up to min(SLOTS, ID_SPACE) timed tasks, fired in schedule order.
// Schedule, cancel of an absent id and run with an empty list: busy while the
//   request is decoded, then its single result appears; the unused opcode gives no
//   result. A new request is taken only once busy has dropped.
// Cancel of a pending id and run with queued tasks: busy until the scan drains; the
//   order list is walked one entry a cycle through a 3-stage read/compare pipe.
// Results are one-cycle strobes, never held off. Synchronous reset empties the queue.
`timescale 1ns / 1ps
module deadline_timer_queue #(
  parameter int SLOTS = dtq_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dtq_pkg::OP_W-1:0]    opcode,
  input  logic [dtq_pkg::ID_W-1:0]    task_id,
  input  logic [dtq_pkg::TIME_W-1:0]  delay,
  input  logic [dtq_pkg::TIME_W-1:0]  now_ms,
  output logic                        valid,
  output logic [dtq_pkg::ST_W-1:0]    status,
  output logic [dtq_pkg::ID_W-1:0]    fired_id,
  output logic                        last
);

  localparam int LIMIT = (SLOTS < dtq_pkg::ID_SPACE) ? SLOTS : dtq_pkg::ID_SPACE;
  localparam int CW    = $clog2(LIMIT + 1);
  localparam int IW    = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam logic [dtq_pkg::ID_W:0] LIMIT_V = (dtq_pkg::ID_W+1)'(LIMIT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN
  } state_t;

  state_t state;

  // latched request
  logic [dtq_pkg::OP_W-1:0]   op_q;
  logic [dtq_pkg::ID_W-1:0]   id_q;
  logic [dtq_pkg::TIME_W-1:0] delay_q;
  logic [dtq_pkg::TIME_W-1:0] now_q;

  logic [LIMIT-1:0] pending;
  logic [CW-1:0]    count;

  // storage
  logic [dtq_pkg::TIME_W-1:0] due_mem [LIMIT];
  logic [dtq_pkg::ID_W-1:0]   ord_mem [LIMIT];

  // scan pipeline
  logic [CW-1:0]              rd_idx;
  logic [CW-1:0]              wr_idx;
  logic                       v1;
  logic                       v2;
  logic [dtq_pkg::ID_W-1:0]   ord_rd;
  logic [dtq_pkg::ID_W-1:0]   ord2;
  logic [dtq_pkg::TIME_W-1:0] due_rd;
  logic                       held_v;
  logic [dtq_pkg::ID_W-1:0]   held_id;

  logic                       alu_sub;
  logic [dtq_pkg::TIME_W-1:0] alu_b;
  logic [dtq_pkg::TIME_W-1:0] alu_sum;

  logic id_ok;
  logic pend_hit;
  logic count_full;
  logic issue;
  logic drop;
  logic scan_end;
  logic is_run;

  logic                     due_we;
  logic                     ord_we;
  logic [IW-1:0]            ord_waddr;
  logic [dtq_pkg::ID_W-1:0] ord_wdata;

  assign alu_sub = (state == S_SCAN);
  assign alu_b   = alu_sub ? due_rd : delay_q;

  dtq_alu u_alu (
    .sub (alu_sub),
    .a   (now_q),
    .b   (alu_b),
    .sum (alu_sum)
  );

  assign busy       = (state != S_IDLE);
  assign is_run     = (op_q == dtq_pkg::OP_RUN);
  assign id_ok      = ({1'b0, id_q} < LIMIT_V);
  assign pend_hit   = id_ok && pending[id_q[IW-1:0]];
  assign count_full = (int'(count) >= dtq_pkg::ID_SPACE);
  assign issue      = (state == S_SCAN) && (rd_idx < count);
  // run drops entries whose difference is non-negative; cancel drops the one id
  assign drop       = is_run ? !alu_sum[dtq_pkg::TIME_W-1] : (ord2 == id_q);
  assign scan_end   = (state == S_SCAN) && !issue && !v1 && !v2;

  always_comb begin
    due_we    = 1'b0;
    ord_we    = 1'b0;
    ord_waddr = count[IW-1:0];
    ord_wdata = id_q;
    if (state == S_DECODE && op_q == dtq_pkg::OP_SCHEDULE && id_ok && !count_full
        && !pend_hit) begin
      due_we = 1'b1;
      ord_we = 1'b1;
    end else if (state == S_SCAN && v2 && !drop) begin
      ord_we    = 1'b1;
      ord_waddr = wr_idx[IW-1:0];
      ord_wdata = ord2;
    end
  end

  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[id_q[IW-1:0]] <= alu_sum;
    end
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd <= ord_mem[rd_idx[IW-1:0]];
    due_rd <= due_mem[ord_rd[IW-1:0]];
    ord2   <= ord_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pending  <= '0;
      count    <= '0;
      valid    <= 1'b0;
      status   <= dtq_pkg::ST_NONE_DUE;
      fired_id <= '0;
      last     <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      held_v   <= 1'b0;
      rd_idx   <= '0;
      wr_idx   <= '0;
      op_q     <= dtq_pkg::OP_SCHEDULE;
      id_q     <= '0;
      delay_q  <= '0;
      now_q    <= '0;
      held_id  <= '0;
    end else begin
      valid <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q    <= opcode;
            id_q    <= task_id;
            delay_q <= delay;
            now_q   <= now_ms;
            state   <= S_DECODE;
          end
        end

        S_DECODE: begin
          rd_idx   <= '0;
          wr_idx   <= '0;
          held_v   <= 1'b0;
          fired_id <= id_q;
          last     <= 1'b1;
          state    <= S_IDLE;
          case (op_q)
            dtq_pkg::OP_SCHEDULE: begin
              valid <= 1'b1;
              if (!id_ok || count_full) begin
                status <= dtq_pkg::ST_NOT_QUEUED;
              end else if (pend_hit) begin
                status <= dtq_pkg::ST_ALREADY;
              end else begin
                status                <= dtq_pkg::ST_QUEUED;
                pending[id_q[IW-1:0]] <= 1'b1;
                count                 <= count + 1'b1;
              end
            end
            dtq_pkg::OP_CANCEL: begin
              if (!pend_hit) begin
                valid  <= 1'b1;
                status <= dtq_pkg::ST_NOT_QUEUED;
              end else begin
                state <= S_SCAN;
              end
            end
            dtq_pkg::OP_RUN: begin
              if (count == '0) begin
                valid    <= 1'b1;
                status   <= dtq_pkg::ST_NONE_DUE;
                fired_id <= '0;
              end else begin
                state <= S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end

        S_SCAN: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
            v1     <= 1'b1;
          end
          v2 <= v1;
          if (v2) begin
            if (!drop) begin
              wr_idx <= wr_idx + 1'b1;
            end else if (is_run) begin
              pending[ord2[IW-1:0]] <= 1'b0;
              // hold each fired task back one step so the final one carries last
              if (held_v) begin
                valid    <= 1'b1;
                status   <= dtq_pkg::ST_FIRED;
                fired_id <= held_id;
                last     <= 1'b0;
              end
              held_v  <= 1'b1;
              held_id <= ord2;
            end
          end
          if (scan_end) begin
            count  <= wr_idx;
            valid  <= 1'b1;
            last   <= 1'b1;
            held_v <= 1'b0;
            state  <= S_IDLE;
            if (!is_run) begin
              status                <= dtq_pkg::ST_CANCELLED;
              fired_id              <= id_q;
              pending[id_q[IW-1:0]] <= 1'b0;
            end else if (held_v) begin
              status   <= dtq_pkg::ST_FIRED;
              fired_id <= held_id;
            end else begin
              status   <= dtq_pkg::ST_NONE_DUE;
              fired_id <= '0;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
